/* rtl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared codes, types and the size-to-order helper.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int KIND_W     = 2;
   localparam int COUNT_W    = 11;
   localparam int PAGE_W     = 14;
   localparam int STATUS_W   = 2;
   localparam int POOL_W     = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // pool geometry: top blocks of 2^TOP_ORDER pages each
   localparam int TOP_BLOCKS = 16;
   localparam int TOP_ORDER  = 10;

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_BLOCK  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD_ADDR  = 2'd3;

   // register index (paddr bit 2)
   localparam logic REG_POOL_BLOCKS = 1'b0;
   localparam logic [POOL_W-1:0] POOL_BLOCKS_RESET = 5'd16;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_UL_RD,
      ST_UL_WR,
      ST_TGL_RD,
      ST_TGL_WR,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_ALLOC,
      OP_FREE,
      OP_INIT
   } op_type;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   granted_page;
   } rsp_type;

   // least k with 2^k >= count, zero counts as one
   function automatic logic [3:0] size_order(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] c1;
      logic [3:0]         ord;
      c1  = (count == '0) ? '0 : count - 1'b1;
      ord = '0;
      for (int b = 0; b < COUNT_W; b++) begin
         if (c1[b]) ord = 4'(b + 1);
      end
      return ord;
   endfunction

endpackage

/* rtl/bpa_ram.sv */
// ----------------------------------------------------------------------------
// Buddy allocator RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 16384,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rdata_ff <= mem_ff[addr];
   end

   assign rd_data = rdata_ff;

endmodule

/* rtl/bpa_seq.sv */
// ----------------------------------------------------------------------------
// Buddy allocator sequencer
// List heads, link and pair-bit memories, and the allocate/free/init walk.
// ----------------------------------------------------------------------------
module bpa_seq import bpa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [COUNT_W-1:0]  req_page_count,
   input  logic [PAGE_W-1:0]   req_freed_page,
   input  logic [POOL_W-1:0]   pool_blocks,
   input  logic                out_free,
   output rsp_type             rsp_o
);

   localparam int POOL_PAGES = TOP_BLOCKS << TOP_ORDER;
   localparam int AW  = $clog2(POOL_PAGES);
   localparam int LW  = $clog2(POOL_PAGES + 1);
   localparam int OW  = $clog2(TOP_ORDER + 1);
   localparam int NBW = $clog2(TOP_BLOCKS + 1);
   localparam logic [LW-1:0] NO_PAGE = LW'(POOL_PAGES);
   localparam logic [OW-1:0] TOP_LVL = OW'(TOP_ORDER);

   state_type          state_ff, state_in;
   op_type             mode_ff, mode_in;
   logic [OW-1:0]      lvl_ff, lvl_in;
   logic [OW-1:0]      order_ff, order_in;
   logic [AW-1:0]      blk_ff, blk_in;
   logic [AW-1:0]      tgt_ff, tgt_in;
   logic [LW-1:0]      hsave_ff, hsave_in;
   logic [LW-1:0]      head_ff [TOP_ORDER+1];
   logic [LW-1:0]      head_in [TOP_ORDER+1];
   logic [LW-1:0]      live_ff, live_in;
   logic [NBW-1:0]     cnt_ff, cnt_in;
   logic [NBW-1:0]     ncnt_ff, ncnt_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic          nx_we, pv_we, pb_we;
   logic [AW-1:0] nx_addr, pv_addr, pb_addr;
   logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;
   logic          pb_wdata, pb_rdata;

   logic [LW-1:0]  pair_full;
   logic [AW-1:0]  pair_addr;
   logic [AW-1:0]  bit_lvl, bit_dn;
   logic [OW-1:0]  dn_lvl;
   logic [LW-1:0]  head_cur;
   logic [OW-1:0]  req_order;
   logic [NBW-1:0] n_blocks;
   logic [NBW-1:0] cnt_nx;
   logic           too_big;

   bpa_ram #(.WIDTH(LW), .DEPTH(POOL_PAGES)) u_next (
      .clock(clock), .wr_en(nx_we), .addr(nx_addr), .wr_data(nx_wdata), .rd_data(nx_rdata)
   );
   bpa_ram #(.WIDTH(LW), .DEPTH(POOL_PAGES)) u_prev (
      .clock(clock), .wr_en(pv_we), .addr(pv_addr), .wr_data(pv_wdata), .rd_data(pv_rdata)
   );
   bpa_ram #(.WIDTH(1), .DEPTH(POOL_PAGES)) u_pair (
      .clock(clock), .wr_en(pb_we), .addr(pb_addr), .wr_data(pb_wdata), .rd_data(pb_rdata)
   );

   // pair bit slot of (lvl, blk): orders packed upward from address 0, lowest order first
   assign pair_full = NO_PAGE - (NO_PAGE >> lvl_ff) + (LW'(blk_ff) >> (lvl_ff + 1'b1));
   assign pair_addr = pair_full[AW-1:0];
   assign bit_lvl   = AW'(1) << lvl_ff;
   assign dn_lvl    = lvl_ff - 1'b1;
   assign bit_dn    = AW'(1) << dn_lvl;
   assign head_cur  = head_ff[lvl_ff];
   assign req_order = OW'(size_order(req_page_count));
   assign too_big   = 32'(req_page_count) > (32'd1 << TOP_ORDER);
   assign cnt_nx    = cnt_ff + 1'b1;

   always_comb begin
      if (pool_blocks == '0) n_blocks = NBW'(1);
      else if (32'(pool_blocks) > TOP_BLOCKS) n_blocks = NBW'(TOP_BLOCKS);
      else n_blocks = NBW'(pool_blocks);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         mode_ff   <= OP_NONE;
         clr_ff    <= '0;
         live_ff   <= '0;
         for (int i = 0; i <= TOP_ORDER; i++) head_ff[i] <= NO_PAGE;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         clr_ff    <= clr_in;
         live_ff   <= live_in;
         for (int i = 0; i <= TOP_ORDER; i++) head_ff[i] <= head_in[i];
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff    <= lvl_in;
      order_ff  <= order_in;
      blk_ff    <= blk_in;
      tgt_ff    <= tgt_in;
      hsave_ff  <= hsave_in;
      cnt_ff    <= cnt_in;
      ncnt_ff   <= ncnt_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      lvl_in    = lvl_ff;
      order_in  = order_ff;
      blk_in    = blk_ff;
      tgt_in    = tgt_ff;
      hsave_in  = hsave_ff;
      live_in   = live_ff;
      cnt_in    = cnt_ff;
      ncnt_in   = ncnt_ff;
      clr_in    = clr_ff;
      status_in = status_ff;
      for (int i = 0; i <= TOP_ORDER; i++) head_in[i] = head_ff[i];
      req_ready = 1'b0;
      nx_we     = 1'b0;
      nx_addr   = tgt_ff;
      nx_wdata  = NO_PAGE;
      pv_we     = 1'b0;
      pv_addr   = tgt_ff;
      pv_wdata  = NO_PAGE;
      pb_we     = 1'b0;
      pb_addr   = pair_addr;
      pb_wdata  = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            pb_we   = 1'b1;
            pb_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(POOL_PAGES - 1)) begin
               clr_in   = '0;
               state_in = (mode_ff == OP_INIT) ? ST_PUSH_A : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               status_in = STAT_OK;
               unique case (req_kind)
                  KIND_INIT: begin
                     mode_in  = OP_INIT;
                     for (int i = 0; i <= TOP_ORDER; i++) head_in[i] = NO_PAGE;
                     live_in  = LW'(n_blocks) << TOP_ORDER;
                     ncnt_in  = n_blocks;
                     cnt_in   = '0;
                     lvl_in   = TOP_LVL;
                     tgt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  KIND_ALLOC, KIND_FREE: begin
                     if (too_big) begin
                        mode_in   = OP_NONE;
                        status_in = STAT_TOO_LARGE;
                        state_in  = ST_DONE;
                     end else if (req_kind == KIND_ALLOC) begin
                        mode_in  = OP_ALLOC;
                        lvl_in   = req_order;
                        order_in = req_order;
                        state_in = ST_SEARCH;
                     end else if (32'(req_freed_page) >= 32'(live_ff)) begin
                        mode_in   = OP_NONE;
                        status_in = STAT_BAD_ADDR;
                        state_in  = ST_DONE;
                     end else begin
                        mode_in  = OP_FREE;
                        lvl_in   = req_order;
                        blk_in   = AW'(req_freed_page) & ~((AW'(1) << req_order) - 1'b1);
                        state_in = ST_FREE_RD;
                     end
                  end
                  default: begin
                     mode_in  = OP_NONE;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (head_cur != NO_PAGE) begin
               blk_in   = head_cur[AW-1:0];
               tgt_in   = head_cur[AW-1:0];
               state_in = ST_UL_RD;
            end else if (lvl_ff == TOP_LVL) begin
               status_in = STAT_NO_BLOCK;
               state_in  = ST_DONE;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         ST_UL_RD: begin
            state_in = ST_UL_WR;
         end
         ST_UL_WR: begin
            if (pv_rdata != NO_PAGE) begin
               nx_we    = 1'b1;
               nx_addr  = pv_rdata[AW-1:0];
               nx_wdata = nx_rdata;
            end else begin
               head_in[lvl_ff] = nx_rdata;
            end
            if (nx_rdata != NO_PAGE) begin
               pv_we    = 1'b1;
               pv_addr  = nx_rdata[AW-1:0];
               pv_wdata = pv_rdata;
            end
            if (mode_ff == OP_FREE) begin
               blk_in   = blk_ff & ~bit_lvl;
               lvl_in   = lvl_ff + 1'b1;
               state_in = ST_FREE_RD;
            end else if (lvl_ff != TOP_LVL) begin
               state_in = ST_TGL_RD;
            end else if (lvl_ff == order_ff) begin
               state_in = ST_DONE;
            end else begin
               lvl_in   = dn_lvl;
               tgt_in   = blk_ff ^ bit_dn;
               state_in = ST_PUSH_A;
            end
         end
         ST_TGL_RD: begin
            state_in = ST_TGL_WR;
         end
         ST_TGL_WR: begin
            pb_we    = 1'b1;
            pb_wdata = ~pb_rdata;
            if (lvl_ff == order_ff) begin
               state_in = ST_DONE;
            end else begin
               lvl_in   = dn_lvl;
               tgt_in   = blk_ff ^ bit_dn;
               state_in = ST_PUSH_A;
            end
         end
         ST_PUSH_A, ST_PUSH_B: begin
            if (state_ff == ST_PUSH_A) begin
               nx_we           = 1'b1;
               nx_wdata        = head_cur;
               pv_we           = 1'b1;
               pv_wdata        = NO_PAGE;
               head_in[lvl_ff] = LW'(tgt_ff);
               hsave_in        = head_cur;
               // split halves mark their pair as one-in-use
               if (mode_ff == OP_ALLOC) begin
                  pb_we    = 1'b1;
                  pb_wdata = 1'b1;
               end
            end else begin
               pv_we    = 1'b1;
               pv_addr  = hsave_ff[AW-1:0];
               pv_wdata = LW'(tgt_ff);
            end
            if (state_ff == ST_PUSH_A && head_cur != NO_PAGE) begin
               state_in = ST_PUSH_B;
            end else if (mode_ff == OP_ALLOC) begin
               if (lvl_ff == order_ff) begin
                  state_in = ST_DONE;
               end else begin
                  lvl_in   = dn_lvl;
                  tgt_in   = blk_ff ^ bit_dn;
                  state_in = ST_PUSH_A;
               end
            end else if (mode_ff == OP_INIT && cnt_nx != ncnt_ff) begin
               cnt_in   = cnt_nx;
               tgt_in   = AW'(cnt_nx) << TOP_ORDER;
               state_in = ST_PUSH_A;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FREE_RD: begin
            if (lvl_ff == TOP_LVL) begin
               tgt_in   = blk_ff;
               state_in = ST_PUSH_A;
            end else begin
               state_in = ST_FREE_CHK;
            end
         end
         ST_FREE_CHK: begin
            pb_we = 1'b1;
            if (!pb_rdata) begin
               pb_wdata = 1'b1;
               tgt_in   = blk_ff;
               state_in = ST_PUSH_A;
            end else begin
               // buddy is free: pull it off its list and merge upward
               pb_wdata = 1'b0;
               tgt_in   = blk_ff ^ bit_lvl;
               state_in = ST_UL_RD;
            end
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_o.valid        = (state_ff == ST_DONE);
   assign rsp_o.status       = status_ff;
   assign rsp_o.granted_page = (status_ff == STAT_OK && mode_ff == OP_ALLOC) ?
                               PAGE_W'(blk_ff) : '0;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted transaction did not start a walk");

   a_search_at_or_above_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lvl_ff >= order_ff))
      else $error("free-list search below requested order");

   a_unlink_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UL_WR) |-> ($past(state_ff) == ST_UL_RD))
      else $error("unlink write without link read");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !out_free) |=> (state_ff == ST_DONE))
      else $error("result dropped while output busy");

endmodule

/* rtl/buddy_page_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator unit
// Allocates and frees power-of-two page blocks out of a pool of top blocks.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel (valid/ready) carries one transaction: kind 0 allocate,
//   1 free, 2 rebuild the pool from csr register pool_blocks (APB, addr 0).
//   rsp_* channel (valid/ready) returns one status/granted_page per request.
// Walk: one transaction at a time. Simple cases (reject, kind 3) go
//   straight to the result; an allocate searches the lists, unlinks the
//   block, toggles its pair bit below the top order and pushes one half
//   per split order; a free checks the pair bit and unlinks the buddy per
//   merged order, then pushes the block. The result is then registered in
//   the rsp register. The single-port link and pair-bit RAMs set the pace.
// Init: clears every pair bit, all TOP_BLOCKS << TOP_ORDER addresses
//   (16384 at default), then pushes each top block onto the top list.
// Reset: the same clearing pass runs after reset; req_ready stays low until
//   it ends. CSR writes are taken at any time.
// Stall: a finished result sits in the rsp register; the next request is
//   accepted meanwhile, and its walk waits at the end until the register
//   frees up.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit import bpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [COUNT_W-1:0]    req_page_count,
   input  logic [PAGE_W-1:0]     req_freed_page,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [PAGE_W-1:0]     rsp_granted_page,
   // APB register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [POOL_W-1:0]   pool_blocks_ff, pool_blocks_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   logic                out_free;
   logic                csr_wr;
   rsp_type             seq_rsp;

   // ---- register port: one register, index in paddr bit 2 ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_POOL_BLOCKS) ?
                       CSR_DATA_W'(pool_blocks_ff) : '0;

   always_comb begin
      pool_blocks_in = pool_blocks_ff;
      if (csr_wr && csr_paddr[2] == REG_POOL_BLOCKS) pool_blocks_in = csr_pwdata[POOL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) pool_blocks_ff <= POOL_BLOCKS_RESET;
      else       pool_blocks_ff <= pool_blocks_in;
   end

   // ---- sequencer: heads, link RAMs, pair-bit RAM ----
   bpa_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_page_count (req_page_count),
      .req_freed_page (req_freed_page),
      .pool_blocks    (pool_blocks_ff),
      .out_free       (out_free),
      .rsp_o          (seq_rsp)
   );

   // ---- response register: decouples the walk from the receiver ----
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      if (seq_rsp.valid && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = seq_rsp.status;
         rsp_page_in   = seq_rsp.granted_page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_page = rsp_page_ff;

endmodule
